@@ hdl/expression_tokenizer_defines.svh @@
// assertion macros for the tokenizer rtl
`ifndef EXPRESSION_TOKENIZER_DEFINES_SVH
`define EXPRESSION_TOKENIZER_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define ET_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ET_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

@@ hdl/exptok_pkg.sv @@
// ----------------------------------------------------------------------------
// exptok_pkg
// types, character codes and class functions for the expression tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package exptok_pkg;

  // character codes
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_CARET   = 8'h5e;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PIPE    = 8'h7c;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // most result transactions one input byte can cause
  localparam int MaxResults = 3;

  // tokenizer state carried between bytes
  typedef struct packed {
    logic       in_quote;
    logic [7:0] quote_char;
    logic       word_open;
    logic       op_pending;
    logic [7:0] held_op;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{
    in_quote:   1'b0,
    quote_char: CH_SPACE,
    word_open:  1'b0,
    op_pending: 1'b0,
    held_op:    8'h00
  };

  // one result transaction
  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       token_end;
    logic       last_of_run;
  } result_t;

  // operators that may pair with a following equals sign
  function automatic logic is_op(input logic [7:0] c);
    return c inside {CH_BANG, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                     CH_GT, CH_LT, CH_EQUAL, CH_CARET};
  endfunction

  // one-character tokens
  function automatic logic is_single(input logic [7:0] c);
    return c inside {CH_AMP, CH_PIPE, CH_COLON, CH_LBRACK, CH_RBRACK,
                     CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_COMMA};
  endfunction

endpackage

`default_nettype wire

@@ hdl/exptok_step.sv @@
// ----------------------------------------------------------------------------
// exptok_step
// combinational step: one byte and the current state give up to three
// result transactions and the next state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exptok_step
  import exptok_pkg::*;
(
  input  tok_state_t    st,
  input  logic [7:0]    char_in,
  input  logic          line_end,
  output tok_state_t    st_next,
  output result_t [2:0] items,
  output logic [1:0]    count
);

  always_comb begin
    tok_state_t    s;
    result_t [2:0] r;
    logic [1:0]    n;
    logic          do_handle;

    s         = st;
    r         = '0;
    n         = 2'd0;
    do_handle = 1'b1;

    // resolve a held operator first
    if (s.op_pending) begin
      s.op_pending = 1'b0;
      if (char_in == CH_EQUAL) begin
        r[n] = '{char_out: s.held_op, has_char: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
        n = n + 2'd1;
        r[n] = '{char_out: char_in, has_char: 1'b1, token_end: 1'b1, last_of_run: 1'b0};
        n = n + 2'd1;
        do_handle = 1'b0;
      end else begin
        r[n] = '{char_out: s.held_op, has_char: 1'b1, token_end: 1'b1, last_of_run: 1'b0};
        n = n + 2'd1;
      end
    end

    // ordinary byte handling
    if (do_handle) begin
      if (s.in_quote) begin
        if (char_in == s.quote_char) begin
          r[n] = '{char_out: char_in, has_char: 1'b1, token_end: 1'b1, last_of_run: 1'b0};
          n = n + 2'd1;
          s.in_quote  = 1'b0;
          s.word_open = 1'b0;
        end else begin
          r[n] = '{char_out: char_in, has_char: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
          n = n + 2'd1;
          s.word_open = 1'b1;
        end
      end else if (char_in == CH_SQUOTE || char_in == CH_DQUOTE) begin
        s.in_quote   = 1'b1;
        s.quote_char = char_in;
        r[n] = '{char_out: char_in, has_char: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
        n = n + 2'd1;
        s.word_open = 1'b1;
      end else if (is_op(char_in)) begin
        if (s.word_open) begin
          r[n] = '{char_out: 8'h00, has_char: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
          n = n + 2'd1;
        end
        s.word_open  = 1'b0;
        s.op_pending = 1'b1;
        s.held_op    = char_in;
      end else if (is_single(char_in)) begin
        if (s.word_open) begin
          r[n] = '{char_out: 8'h00, has_char: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
          n = n + 2'd1;
        end
        s.word_open = 1'b0;
        r[n] = '{char_out: char_in, has_char: 1'b1, token_end: 1'b1, last_of_run: 1'b0};
        n = n + 2'd1;
      end else if (char_in == CH_NEWLINE || char_in == CH_SPACE) begin
        if (s.word_open) begin
          r[n] = '{char_out: 8'h00, has_char: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
          n = n + 2'd1;
        end
        s.word_open = 1'b0;
      end else begin
        r[n] = '{char_out: char_in, has_char: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
        n = n + 2'd1;
        s.word_open = 1'b1;
      end
    end

    // flush at the end of the line
    if (line_end) begin
      if (s.op_pending) begin
        r[n] = '{char_out: s.held_op, has_char: 1'b1, token_end: 1'b1, last_of_run: 1'b0};
        n = n + 2'd1;
      end else if (s.word_open) begin
        r[n] = '{char_out: 8'h00, has_char: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
        n = n + 2'd1;
      end
      s = TOK_RESET;
    end

    // mark the final transaction of the run
    case (n)
      2'd1:    r[0].last_of_run = 1'b1;
      2'd2:    r[1].last_of_run = 1'b1;
      2'd3:    r[2].last_of_run = 1'b1;
      default: ;
    endcase

    st_next = s;
    items   = r;
    count   = n;
  end

endmodule

`default_nettype wire

@@ hdl/expression_tokenizer.sv @@
// ----------------------------------------------------------------------------
// expression_tokenizer
// streams an expression line byte by byte and returns token characters
// with token end and run end marks
// ----------------------------------------------------------------------------
// path: a byte is held in the input register, then its results (0..3) load the result buffer
// throughput: one result transaction per cycle while out_stall is low; a held byte
//   loads only as the last result of the byte before it is taken from the three-entry result buffer
// reset: synchronous, clears tokenizer state, input register valid flag and buffer count
`timescale 1ns / 1ps
`default_nettype none
`include "expression_tokenizer_defines.svh"

module expression_tokenizer
  import exptok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       has_char,
  output logic       token_end,
  output logic       last_of_run
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_char;
  logic       hold_last;

  // tokenizer state
  tok_state_t state;
  tok_state_t state_next;

  // result buffer, entry 0 is on the output
  result_t [2:0] res;
  logic [1:0]    cnt;

  result_t [2:0] step_items;
  logic [1:0]    step_count;

  logic out_acc;
  logic in_acc;
  logic load_ok;
  logic consume;

  // handshake
  assign out_valid = (cnt != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign load_ok   = (cnt == 2'd0) || (cnt == 2'd1 && out_acc);
  assign consume   = hold_valid && load_ok;
  assign in_stall  = hold_valid && !load_ok;
  assign in_acc    = in_valid && !in_stall;

  assign char_out    = res[0].char_out;
  assign has_char    = res[0].has_char;
  assign token_end   = res[0].token_end;
  assign last_of_run = res[0].last_of_run;

  // byte step logic
  exptok_step u_step (
    .st       (state),
    .char_in  (hold_char),
    .line_end (hold_last),
    .st_next  (state_next),
    .items    (step_items),
    .count    (step_count)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      state      <= TOK_RESET;
      cnt        <= 2'd0;
    end else begin
      if (in_acc) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (consume) begin
        state <= state_next;
        cnt   <= step_count;
      end else if (out_acc) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_char <= char_in;
      hold_last <= line_end;
    end
    if (consume) begin
      res <= step_items;
    end else if (out_acc) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  // run end mark sits on the final buffered transaction only
  logic last_mark_ok;
  assign last_mark_ok = (cnt == 2'd0) ||
                        (cnt == 2'd1 && res[0].last_of_run) ||
                        (cnt == 2'd2 && res[1].last_of_run && !res[0].last_of_run) ||
                        (cnt == 2'd3 && res[2].last_of_run && !res[1].last_of_run &&
                         !res[0].last_of_run);

  // assertions
  `ET_ASSERT(a_quote_no_op, clk, rst, state.in_quote |-> !state.op_pending, "op held in quote")
  `ET_ASSERT(a_op_word_closed, clk, rst, state.op_pending |-> !state.word_open, "word with op")
  `ET_ASSERT(a_last_on_top, clk, rst, last_mark_ok, "run end mark misplaced")
  `ET_ASSERT(a_line_reset, clk, rst, (consume && hold_last) |=> (state == TOK_RESET), "no reset")

endmodule

`default_nettype wire
